// ===== design/hsip_pkg.sv =====
package hsip_pkg;

   // fixed field widths
   localparam int HASH_W     = 32;
   localparam int MULT_W     = 10;
   localparam int STEP_W     = 9;
   localparam int TSIZE_W    = 10;
   localparam int BYTE_W     = 8;
   localparam int SLOT_OUT_W = 9;
   localparam int COLL_W     = 10;
   localparam int SUM_W      = 18;
   localparam int WORST_W    = 9;
   localparam int CNT_W      = 6;

   localparam int CSR_DATA_W = 10;
   localparam int CSR_ADDR_W = 2;
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 64;

   localparam int TABLE_SLOTS_MAX_DEF = 512;

   localparam logic [MULT_W-1:0]  MULT_RST  = 10'd31;
   localparam logic [STEP_W-1:0]  STEP_RST  = 9'd1;
   localparam logic [TSIZE_W-1:0] TSIZE_RST = 10'd139;

   localparam logic [COLL_W-1:0]  COLL_SAT  = 10'd1023;
   localparam logic [SUM_W-1:0]   SUM_SAT   = 18'd262143;
   localparam logic [WORST_W-1:0] WORST_SAT = 9'd511;

   localparam logic CMD_KEY   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_HASH_MULT  = 2'd0,
      CSR_PROBE_STEP = 2'd1,
      CSR_TABLE_SIZE = 2'd2
   } csr_index_type;

   // one occupancy write
   typedef struct packed {
      logic we;
      logic wdata;
   } occ_wr_type;

endpackage

// ===== design/hash_slot_insert_probe_core.sv =====
// Channel  Dir  Handshake                Payload
// req      in   req_tvalid/req_tready    tdata: key_byte; tlast: last_byte; tuser: command
// rsp      out  rsp_tvalid/rsp_tready    tdata: slot, stats, table_full (see port)
// csr      in   csr_we (no wait)         csr_addr: register index; csr_wdata: value
//
// A key byte that is not last is folded into the hash by a multiply-add on accept.
// A last byte runs the hash remainder, then the step remainder, then the probe walk up to
// a free slot or until the table is found full; remainders and probe wraparound
// share one compare-subtract unit, and each probe is a registered RAM read plus a check.
// Reset and the clear command start a clearing pass over TABLE_SLOTS_MAX slots; req_tready
// is low during the pass. A finished result sits in the output register; the probe
// sequencer holds only if the previous result has not yet been taken.
module hash_slot_insert_probe_core #(
   parameter int TABLE_SLOTS_MAX = hsip_pkg::TABLE_SLOTS_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [hsip_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] key_byte
   input  logic                            req_tlast,   // last_byte
   input  logic                            req_tuser,   // command
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [8:0] slot_index, [9] first_collided, [18:10] probe_count, [28:19] collision_total,
   // [46:29] compare_total, [55:47] compare_worst, [56] table_full, [63:57] zero
   output logic [hsip_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [hsip_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [hsip_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int SW = $clog2(TABLE_SLOTS_MAX);
   localparam int ZW = $clog2(TABLE_SLOTS_MAX) + 1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_HMOD,
      ST_SMOD,
      ST_PRB_RD,
      ST_PRB_CHK
   } state_type;

   state_type state_ff;

   logic [hsip_pkg::MULT_W-1:0]  mult_ff;
   logic [hsip_pkg::STEP_W-1:0]  step_cfg_ff;
   logic [hsip_pkg::TSIZE_W-1:0] tsize_ff;

   logic [hsip_pkg::HASH_W-1:0]  hash_ff;
   logic [hsip_pkg::HASH_W-1:0]  hash_in;
   logic [hsip_pkg::HASH_W-1:0]  div_ff;
   logic [hsip_pkg::CNT_W-1:0]   cnt_ff;
   logic [ZW-1:0]                rem_ff;
   logic [ZW-1:0]                size_ff;
   logic [ZW-1:0]                size_use;
   logic [ZW-1:0]                pos_ff;
   logic [ZW-1:0]                step_ff;
   logic [ZW-1:0]                k_ff;
   logic                         first_ff;
   logic [SW-1:0]                clr_ptr_ff;

   logic [hsip_pkg::COLL_W-1:0]  coll_ff;
   logic [hsip_pkg::SUM_W-1:0]   sum_ff;
   logic [hsip_pkg::WORST_W-1:0] worst_ff;
   logic [hsip_pkg::COLL_W-1:0]  coll_in;
   logic [hsip_pkg::SUM_W-1:0]   sum_in;
   logic [hsip_pkg::WORST_W-1:0] worst_in;
   logic [hsip_pkg::SUM_W:0]     sum_wide;
   logic [hsip_pkg::WORST_W-1:0] k_sat;

   logic                            rsp_valid_ff;
   logic [hsip_pkg::SLOT_OUT_W-1:0] rsp_slot_ff;
   logic                            rsp_first_ff;
   logic [hsip_pkg::SLOT_OUT_W-1:0] rsp_probes_ff;
   logic [hsip_pkg::COLL_W-1:0]     rsp_coll_ff;
   logic [hsip_pkg::SUM_W-1:0]      rsp_sum_ff;
   logic [hsip_pkg::WORST_W-1:0]    rsp_worst_ff;
   logic                            rsp_full_ff;

   logic                 req_acc;
   logic                 out_free;
   logic                 occ_rdata;
   logic                 collided_now;
   logic                 probe_found;
   logic                 probe_full;
   logic                 probe_done;
   logic [ZW:0]          cs_a;
   logic [ZW-1:0]        cs_r;
   logic [SW-1:0]        occ_waddr;
   hsip_pkg::occ_wr_type occ_wr;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign hash_in = hash_ff * hsip_pkg::HASH_W'(mult_ff)
                  + hsip_pkg::HASH_W'(req_tdata[hsip_pkg::BYTE_W-1:0]);

   always_comb begin
      if (tsize_ff < hsip_pkg::TSIZE_W'(2)) begin
         size_use = ZW'(2);
      end else if (32'(tsize_ff) > TABLE_SLOTS_MAX) begin
         size_use = ZW'(TABLE_SLOTS_MAX);
      end else begin
         size_use = ZW'(tsize_ff);
      end
   end

   // shared unit: remainder step while dividing, wraparound while probing
   always_comb begin
      if (state_ff == ST_PRB_CHK) begin
         cs_a = (ZW+1)'(pos_ff) + (ZW+1)'(step_ff);
      end else begin
         cs_a = {rem_ff, div_ff[hsip_pkg::HASH_W-1]};
      end
   end

   hsip_cmpsub #(.ZW(ZW)) u_cmpsub (
      .a(cs_a),
      .b(size_ff),
      .r(cs_r)
   );

   // probe outcome
   assign collided_now = (k_ff == '0) ? occ_rdata : first_ff;
   assign probe_found  = !occ_rdata;
   assign probe_full   = occ_rdata && ((k_ff + ZW'(1)) == size_ff);
   assign probe_done   = (state_ff == ST_PRB_CHK) && (probe_found || probe_full) && out_free;

   // statistics on a successful insert
   assign sum_wide = (hsip_pkg::SUM_W+1)'(sum_ff) + (hsip_pkg::SUM_W+1)'(k_ff);
   assign k_sat    = (32'(k_ff) > 32'(hsip_pkg::WORST_SAT)) ? hsip_pkg::WORST_SAT
                                                             : hsip_pkg::WORST_W'(k_ff);

   always_comb begin
      coll_in = coll_ff;
      if (collided_now && (coll_ff != hsip_pkg::COLL_SAT)) begin
         coll_in = coll_ff + hsip_pkg::COLL_W'(1);
      end
      if (sum_wide > (hsip_pkg::SUM_W+1)'(hsip_pkg::SUM_SAT)) begin
         sum_in = hsip_pkg::SUM_SAT;
      end else begin
         sum_in = sum_wide[hsip_pkg::SUM_W-1:0];
      end
      worst_in = (k_sat >= worst_ff) ? k_sat : worst_ff;
   end

   always_comb begin
      if (state_ff == ST_CLEAR) begin
         occ_wr.we    = 1'b1;
         occ_wr.wdata = 1'b0;
         occ_waddr    = clr_ptr_ff;
      end else begin
         occ_wr.we    = probe_done && probe_found;
         occ_wr.wdata = 1'b1;
         occ_waddr    = pos_ff[SW-1:0];
      end
   end

   hsip_occ_ram #(.SLOTS(TABLE_SLOTS_MAX), .SW(SW)) u_occ_ram (
      .clock(clock),
      .wr(occ_wr),
      .waddr(occ_waddr),
      .raddr(pos_ff[SW-1:0]),
      .rdata(occ_rdata)
   );

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         mult_ff     <= hsip_pkg::MULT_RST;
         step_cfg_ff <= hsip_pkg::STEP_RST;
         tsize_ff    <= hsip_pkg::TSIZE_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            hsip_pkg::CSR_HASH_MULT:  mult_ff     <= csr_wdata[hsip_pkg::MULT_W-1:0];
            hsip_pkg::CSR_PROBE_STEP: step_cfg_ff <= csr_wdata[hsip_pkg::STEP_W-1:0];
            hsip_pkg::CSR_TABLE_SIZE: tsize_ff    <= csr_wdata[hsip_pkg::TSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ptr_ff   <= '0;
         hash_ff      <= '0;
         coll_ff      <= '0;
         sum_ff       <= '0;
         worst_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (probe_done) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ptr_ff <= clr_ptr_ff + SW'(1);
               if (clr_ptr_ff == SW'(TABLE_SLOTS_MAX - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_acc) begin
                  if (req_tuser == hsip_pkg::CMD_CLEAR) begin
                     hash_ff    <= '0;
                     coll_ff    <= '0;
                     sum_ff     <= '0;
                     worst_ff   <= '0;
                     clr_ptr_ff <= '0;
                     state_ff   <= ST_CLEAR;
                  end else if (req_tlast) begin
                     hash_ff  <= '0;
                     div_ff   <= hash_in;
                     rem_ff   <= '0;
                     cnt_ff   <= hsip_pkg::CNT_W'(hsip_pkg::HASH_W);
                     size_ff  <= size_use;
                     state_ff <= ST_HMOD;
                  end else begin
                     hash_ff <= hash_in;
                  end
               end
            end
            ST_HMOD: begin
               cnt_ff <= cnt_ff - hsip_pkg::CNT_W'(1);
               if (cnt_ff == hsip_pkg::CNT_W'(1)) begin
                  pos_ff   <= cs_r;
                  rem_ff   <= '0;
                  div_ff   <= {step_cfg_ff, (hsip_pkg::HASH_W - hsip_pkg::STEP_W)'(0)};
                  cnt_ff   <= hsip_pkg::CNT_W'(hsip_pkg::STEP_W);
                  state_ff <= ST_SMOD;
               end else begin
                  rem_ff <= cs_r;
                  div_ff <= div_ff << 1;
               end
            end
            ST_SMOD: begin
               cnt_ff <= cnt_ff - hsip_pkg::CNT_W'(1);
               if (cnt_ff == hsip_pkg::CNT_W'(1)) begin
                  step_ff  <= cs_r;
                  k_ff     <= '0;
                  state_ff <= ST_PRB_RD;
               end else begin
                  rem_ff <= cs_r;
                  div_ff <= div_ff << 1;
               end
            end
            ST_PRB_RD: begin
               state_ff <= ST_PRB_CHK;
            end
            ST_PRB_CHK: begin
               if (k_ff == '0) begin
                  first_ff <= occ_rdata;
               end
               if (probe_done) begin
                  rsp_first_ff <= collided_now;
                  rsp_full_ff  <= probe_full && !probe_found;
                  if (probe_found) begin
                     coll_ff       <= coll_in;
                     sum_ff        <= sum_in;
                     worst_ff      <= worst_in;
                     rsp_slot_ff   <= hsip_pkg::SLOT_OUT_W'(pos_ff);
                     rsp_probes_ff <= k_sat;
                     rsp_coll_ff   <= coll_in;
                     rsp_sum_ff    <= sum_in;
                     rsp_worst_ff  <= worst_in;
                  end else begin
                     rsp_slot_ff   <= '0;
                     rsp_probes_ff <= '0;
                     rsp_coll_ff   <= coll_ff;
                     rsp_sum_ff    <= sum_ff;
                     rsp_worst_ff  <= worst_ff;
                  end
                  state_ff <= ST_IDLE;
               end else if (occ_rdata && !probe_full) begin
                  pos_ff   <= cs_r;
                  k_ff     <= k_ff + ZW'(1);
                  state_ff <= ST_PRB_RD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_full_ff, rsp_worst_ff, rsp_sum_ff, rsp_coll_ff,
                        rsp_probes_ff, rsp_first_ff, rsp_slot_ff};

   // a clear request always starts a clearing pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser) |=> (state_ff == ST_CLEAR))
      else $error("clear request did not start clearing pass");

   // probe walk stays inside the table
   a_probe_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PRB_CHK) |-> ((k_ff < size_ff) && (pos_ff < size_ff)))
      else $error("probe position or count out of range");

   // a full-table result carries no slot and no probes
   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_full_ff) |-> (rsp_first_ff && (rsp_slot_ff == '0)
                                         && (rsp_probes_ff == '0)))
      else $error("table-full result with nonzero fields");

   // a pending result is never overwritten by the sequencer
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !probe_done)
      else $error("result overwritten before taken");

endmodule

// ===== design/hsip_cmpsub.sv =====
// Shared compare-subtract: r = (a >= b) ? a - b : a, with a < 2*b.
// Serves the restoring remainder steps and the probe wraparound.
module hsip_cmpsub #(
   parameter int ZW = 10
) (
   input  logic [ZW:0]   a,
   input  logic [ZW-1:0] b,
   output logic [ZW-1:0] r
);

   logic [ZW:0] diff;

   assign diff = a - {1'b0, b};
   assign r    = (a >= {1'b0, b}) ? diff[ZW-1:0] : a[ZW-1:0];

endmodule

// ===== design/hsip_occ_ram.sv =====
module hsip_occ_ram #(
   parameter int SLOTS = hsip_pkg::TABLE_SLOTS_MAX_DEF,
   parameter int SW    = $clog2(SLOTS)
) (
   input  logic                 clock,
   input  hsip_pkg::occ_wr_type wr,
   input  logic [SW-1:0]        waddr,
   input  logic [SW-1:0]        raddr,
   output logic                 rdata
);

   logic mem [SLOTS];
   logic rdata_ff;

   always_ff @(posedge clock) begin
      if (wr.we) begin
         mem[waddr] <= wr.wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== bench/testbench.sv =====
module testbench;
   import hsip_pkg::*;

   localparam int TABLE_SLOTS = TABLE_SLOTS_MAX_DEF;
   localparam int unsigned DRAIN_CYCLES = 600;          // covers a clearing pass
   localparam int unsigned RESULT_WAIT_MAX = 200_000;
   localparam int unsigned RANDOM_ITEMS = 1830;

   typedef struct {
      logic [SLOT_OUT_W-1:0] slot;
      logic                  collided;
      logic [WORST_W-1:0]    probes;
      logic [COLL_W-1:0]     collisions;
      logic [SUM_W-1:0]      compares;
      logic [WORST_W-1:0]    worst;
      logic                  full;
   } slot_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;    // [7:0] key_byte
   logic                  req_tlast = 1'b0;  // last_byte
   logic                  req_tuser = 1'b0;  // command
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // [8:0] slot_index, [9] first_collided, [18:10] probe_count, [28:19] collision_total,
   // [46:29] compare_total, [55:47] compare_worst, [56] table_full
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // shadow of the insert engine
   logic [MULT_W-1:0]  hash_mult;
   logic [STEP_W-1:0]  probe_step_reg;
   logic [TSIZE_W-1:0] table_size_reg;
   bit                 slot_taken [TABLE_SLOTS];
   logic [HASH_W-1:0]  key_hash;
   int unsigned        collision_count;
   int unsigned        compare_sum;
   int unsigned        compare_worst;

   slot_report_type pending_reports [$];
   int unsigned     mismatches = 0;
   bit              gaps_on = 1'b1;
   bit              stalls_on = 1'b1;
   int unsigned     stall_left = 0;

   hash_slot_insert_probe_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic void clear_table();
      foreach (slot_taken[i]) slot_taken[i] = 1'b0;
      key_hash = '0;
      collision_count = 0;
      compare_sum = 0;
      compare_worst = 0;
   endfunction

   function automatic void predict_insert(logic cmd, logic [BYTE_W-1:0] kb, logic last);
      int unsigned span, stride, pos, hops;
      logic home_taken, found;
      slot_report_type rep;
      if (cmd == CMD_CLEAR) begin
         clear_table();
         return;
      end
      key_hash = key_hash * HASH_W'(hash_mult) + HASH_W'(kb);
      if (!last) return;
      span = table_size_reg;
      if (span < 2) span = 2;
      if (span > TABLE_SLOTS) span = TABLE_SLOTS;
      stride = probe_step_reg % span;
      pos = key_hash % span;
      key_hash = '0;
      home_taken = slot_taken[pos];
      found = 1'b0;
      hops = 0;
      // a stride sharing a factor with the size may miss free slots
      while (hops < span && !found) begin
         if (!slot_taken[pos]) found = 1'b1;
         else begin
            pos = (pos + stride) % span;
            hops++;
         end
      end
      if (found) begin
         slot_taken[pos] = 1'b1;
         if (home_taken && collision_count < COLL_SAT) collision_count++;
         compare_sum = compare_sum + hops;
         if (compare_sum > SUM_SAT) compare_sum = SUM_SAT;
         if (hops > WORST_SAT) hops = WORST_SAT;
         if (hops >= compare_worst) compare_worst = hops;
      end else begin
         pos = 0;
         hops = 0;
      end
      rep.slot = SLOT_OUT_W'(pos);
      rep.collided = home_taken;
      rep.probes = WORST_W'(hops);
      rep.collisions = COLL_W'(collision_count);
      rep.compares = SUM_W'(compare_sum);
      rep.worst = WORST_W'(compare_worst);
      rep.full = !found;
      pending_reports.push_back(rep);
   endfunction

   function automatic void flag_mismatch(string what, longint unsigned want,
                                         longint unsigned got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $time);
   endfunction

   function automatic void check_field(string what, longint unsigned want,
                                       longint unsigned got);
      if (want != got) flag_mismatch(what, want, got);
   endfunction

   always @(posedge clock) begin
      slot_report_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_reports.size() == 0) flag_mismatch("unrequested result", 0, rsp_tdata);
         else begin
            want = pending_reports.pop_front();
            check_field("slot_index", want.slot, rsp_tdata[8:0]);
            check_field("first_collided", want.collided, rsp_tdata[9]);
            check_field("probe_count", want.probes, rsp_tdata[18:10]);
            check_field("collision_total", want.collisions, rsp_tdata[28:19]);
            check_field("compare_total", want.compares, rsp_tdata[46:29]);
            check_field("compare_worst", want.worst, rsp_tdata[55:47]);
            check_field("table_full", want.full, rsp_tdata[56]);
         end
      end
   end

   // result-side backpressure in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stalls_on && $urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(0, 16);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_request(logic cmd, logic [BYTE_W-1:0] kb, logic last);
      if (gaps_on && $urandom_range(0, 6) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= kb;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      predict_insert(cmd, kb, last);
   endtask

   task automatic send_key(int unsigned len);
      for (int unsigned i = 1; i <= len; i++)
         send_request(CMD_KEY, BYTE_W'($urandom), i == len);
   endtask

   task automatic wait_for_results(int unsigned settle);
      int unsigned waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (pending_reports.size() != 0 && waited < RESULT_WAIT_MAX) begin
         @(posedge clock);
         waited++;
      end
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_HASH_MULT: hash_mult = value[MULT_W-1:0];
         CSR_PROBE_STEP: probe_step_reg = value[STEP_W-1:0];
         CSR_TABLE_SIZE: table_size_reg = value[TSIZE_W-1:0];
         default: ;
      endcase
   endtask

   task automatic load_settings(logic [CSR_DATA_W-1:0] mult, logic [CSR_DATA_W-1:0] step,
                                logic [CSR_DATA_W-1:0] size);
      wait_for_results(DRAIN_CYCLES);
      write_reg(CSR_HASH_MULT, mult);
      write_reg(CSR_PROBE_STEP, step);
      write_reg(CSR_TABLE_SIZE, size);
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_request(CMD_KEY, 8'h00, 1'b0);
      send_request(CMD_KEY, 8'hFF, 1'b1);
      send_request(CMD_KEY, 8'hFF, 1'b1);
   endtask

   task automatic test_multiplier_extremes();
      load_settings(10'd1023, 10'd1, 10'd512);
      repeat (3) send_request(CMD_KEY, 8'hFF, 1'b0);
      send_request(CMD_KEY, 8'hFF, 1'b1);   // hash wraps past 32 bits
      load_settings(10'd1, 10'd1, 10'd512);
      send_request(CMD_KEY, 8'h80, 1'b0);
      send_request(CMD_KEY, 8'h7F, 1'b1);
   endtask

   task automatic test_clear_command();
      send_request(CMD_KEY, 8'h42, 1'b0);
      send_request(CMD_CLEAR, 8'hA5, 1'b1);  // byte and last are ignored
      send_request(CMD_KEY, 8'h07, 1'b1);
   endtask

   task automatic test_probe_step();
      load_settings(10'd31, 10'd2, 10'd4);
      send_request(CMD_CLEAR, 8'h00, 1'b0);
      // stride 2 over 4 slots only reaches even slots
      repeat (3) send_request(CMD_KEY, 8'h00, 1'b1);
      load_settings(10'd31, 10'd0, 10'd4);
      repeat (2) send_request(CMD_KEY, 8'h01, 1'b1);
      load_settings(10'd31, 10'h3FF, 10'd4);  // upper bit dropped, then 511 mod 4
      send_request(CMD_KEY, 8'h01, 1'b1);
   endtask

   task automatic test_size_clamp_and_full();
      load_settings(10'd31, 10'd1, 10'd0);    // clamps to two slots
      send_request(CMD_CLEAR, 8'hFF, 1'b0);
      repeat (3) send_request(CMD_KEY, 8'hFF, 1'b1);
      load_settings(10'd31, 10'd1, 10'd1023);
      send_request(CMD_KEY, 8'h80, 1'b1);
   endtask

   task automatic test_random_keys(int unsigned budget);
      int unsigned sent, phase_end, n, roll, span;
      logic [CSR_DATA_W-1:0] mult, step, size;
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(0, 9))
            0: size = 10'd512;
            1: size = CSR_DATA_W'($urandom_range(0, 1023));
            default: size = CSR_DATA_W'($urandom_range(2, 48));
         endcase
         span = size < 2 ? 2 : (size > TABLE_SLOTS ? TABLE_SLOTS : size);
         case ($urandom_range(0, 7))
            0: step = '0;
            1: step = CSR_DATA_W'($urandom_range(0, 1023));
            default: step = CSR_DATA_W'($urandom_range(1, span - 1));
         endcase
         case ($urandom_range(0, 5))
            0: mult = 10'd1;
            1: mult = 10'd1023;
            default: mult = CSR_DATA_W'($urandom_range(0, 1023));
         endcase
         load_settings(mult, step, size);
         if (sent >= budget - budget / 8) begin
            gaps_on = 1'b0;
            stalls_on = 1'b0;
         end else begin
            gaps_on = $urandom_range(0, 3) != 0;
            stalls_on = $urandom_range(0, 3) != 0;
         end
         if ($urandom_range(0, 1) == 0) begin
            send_request(CMD_CLEAR, BYTE_W'($urandom), 1'($urandom));
            sent++;
         end
         phase_end = sent + $urandom_range(60, 180);
         while (sent < phase_end && sent < budget) begin
            roll = $urandom_range(0, 39);
            if (roll == 0) begin
               send_request(CMD_CLEAR, BYTE_W'($urandom), 1'($urandom));
               sent++;
            end else if (roll == 1) begin
               // key abandoned by a clear
               n = $urandom_range(1, 3);
               repeat (n) send_request(CMD_KEY, BYTE_W'($urandom), 1'b0);
               send_request(CMD_CLEAR, BYTE_W'($urandom), 1'($urandom));
               sent += n + 1;
            end else begin
               n = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
               send_key(n);
               sent += n;
            end
         end
      end
   endtask

   initial begin
      hash_mult = MULT_RST;
      probe_step_reg = STEP_RST;
      table_size_reg = TSIZE_RST;
      clear_table();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_multiplier_extremes();
      test_clear_command();
      test_probe_step();
      test_size_clamp_and_full();
      test_random_keys(RANDOM_ITEMS);
      wait_for_results(DRAIN_CYCLES);
      if (pending_reports.size() != 0)
         flag_mismatch("results never returned", 0, pending_reports.size());
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #96_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
